/* hw/rtl/ptcc_pkg.sv */
// ----------------------------------------------------------------------------
// ptcc_pkg: shared types, constants and functions of the P1 telegram checker
// Holds the classified request type, status codes, character constants,
// the CRC-16/ARC byte update and the hex digit decoder.
// ----------------------------------------------------------------------------
package ptcc_pkg;

  localparam int FRAME_BUFFER_BYTES_DEF = 2048;
  localparam int QUEUE_DEPTH            = 2;

  localparam int LEN_W    = 11;
  localparam int CRC_W    = 16;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_MATCH    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

  // One request after classification by the front end
  typedef struct packed {
    logic       flush;
    logic [7:0] data;
    logic       is_bang;
    logic       is_newline;
    logic       hex_ok;
    logic [3:0] hex_val;
  } ptcc_item_t;

  // Handshake between queue and back end
  typedef struct packed {
    logic       valid;
    ptcc_item_t item;
  } ptcc_head_t;

  // Reflected CRC-16/ARC, one byte, bitwise
  function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc,
                                                 input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Returns {valid, digit}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    logic       ok;
    d  = 8'h00;
    ok = 1'b0;
    if (c inside {[8'h30:8'h39]}) begin
      d  = c - 8'h30;
      ok = 1'b1;
    end else if (c inside {[8'h61:8'h66]}) begin
      d  = c - 8'h57;
      ok = 1'b1;
    end else if (c inside {[8'h41:8'h46]}) begin
      d  = c - 8'h37;
      ok = 1'b1;
    end
    return {ok, d[3:0]};
  endfunction

endpackage

/* hw/rtl/ptcc_front.sv */
// ----------------------------------------------------------------------------
// ptcc_front: request classifier
// Decodes each incoming byte into flags and a hex digit and hands the
// classified request to the queue.
// ----------------------------------------------------------------------------
module ptcc_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  logic [7:0]           data_byte,
  input  logic                 q_full,
  output logic                 push,
  output ptcc_pkg::ptcc_item_t push_item
);
  import ptcc_pkg::*;

  logic [4:0] hex;

  always_comb begin
    hex                  = hex_digit(data_byte);
    push_item.flush      = kind;
    push_item.data       = data_byte;
    push_item.is_bang    = (data_byte == CH_BANG);
    push_item.is_newline = (data_byte == CH_NEWLINE);
    push_item.hex_ok     = hex[4];
    push_item.hex_val    = hex[3:0];
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

/* hw/rtl/ptcc_queue.sv */
// ----------------------------------------------------------------------------
// ptcc_queue: short request queue
// Register-based FIFO between the classifier and the frame engine.
// ----------------------------------------------------------------------------
module ptcc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ptcc_pkg::ptcc_item_t push_item,
  output logic                 full,
  output ptcc_pkg::ptcc_head_t head,
  input  logic                 pop
);
  import ptcc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  ptcc_item_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count above depth");
  a_push_moves_count: assert property (@(posedge clk) disable iff (rst)
    (push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue push lost");
`endif

endmodule

/* hw/rtl/ptcc_back.sv */
// ----------------------------------------------------------------------------
// ptcc_back: frame engine
// Keeps byte count, running CRC, '!' snapshot and trailer digits; loads
// frame and overflow results into the output register.
// ----------------------------------------------------------------------------
module ptcc_back #(
  parameter int FRAME_BUFFER_BYTES = ptcc_pkg::FRAME_BUFFER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ptcc_pkg::ptcc_head_t            head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ptcc_pkg::STATUS_W-1:0]   status,
  output logic [ptcc_pkg::LEN_W-1:0]      frame_length,
  output logic [ptcc_pkg::CRC_W-1:0]      crc_received,
  output logic [ptcc_pkg::CRC_W-1:0]      crc_computed
);
  import ptcc_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BUFFER_BYTES);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(FRAME_BUFFER_BYTES - 1);

  logic [CNT_W-1:0] byte_count,       byte_count_next;
  logic [15:0]      crc_running,      crc_running_next;
  logic [15:0]      crc_at_bang,      crc_at_bang_next;
  logic             bang_seen,        bang_seen_next;
  logic [2:0]       chars_after_bang, chars_after_bang_next;
  logic [15:0]      hex_accum,        hex_accum_next;
  logic             hex_all_valid,    hex_all_valid_next;

  logic                   take;
  logic                   res_fire;
  logic [STATUS_W-1:0]    res_status;
  logic [LEN_W-1:0]       res_length;
  logic [15:0]            res_rx;
  logic [15:0]            res_calc;
  logic [CNT_W-1:0]       cnt_inc;
  logic [CNT_W+LEN_W-1:0] len_wide;
  logic [15:0]            crc_new;
  ptcc_item_t             it;

  assign it   = head.item;
  assign take = head.valid && (!out_valid || out_ready);
  assign pop  = take;

  always_comb begin
    byte_count_next       = byte_count;
    crc_running_next      = crc_running;
    crc_at_bang_next      = crc_at_bang;
    bang_seen_next        = bang_seen;
    chars_after_bang_next = chars_after_bang;
    hex_accum_next        = hex_accum;
    hex_all_valid_next    = hex_all_valid;
    res_fire              = 1'b0;
    res_status            = ST_MATCH;
    res_length            = '0;
    res_rx                = '0;
    res_calc              = '0;
    cnt_inc               = byte_count + 1'b1;
    len_wide              = {{LEN_W{1'b0}}, cnt_inc};
    crc_new               = crc16_arc_byte(crc_running, it.data);

    if (it.flush) begin
      byte_count_next       = '0;
      crc_running_next      = '0;
      crc_at_bang_next      = '0;
      bang_seen_next        = 1'b0;
      chars_after_bang_next = '0;
      hex_accum_next        = '0;
      hex_all_valid_next    = 1'b1;
    end else if (byte_count >= CNT_LIMIT) begin
      // drop the byte, restart the frame, report overflow
      byte_count_next       = '0;
      crc_running_next      = '0;
      crc_at_bang_next      = '0;
      bang_seen_next        = 1'b0;
      chars_after_bang_next = '0;
      hex_accum_next        = '0;
      hex_all_valid_next    = 1'b1;
      res_fire              = 1'b1;
      res_status            = ST_OVERFLOW;
    end else if (it.is_newline && bang_seen && chars_after_bang[2] && hex_all_valid) begin
      res_fire              = 1'b1;
      res_status            = (hex_accum == crc_at_bang) ? ST_MATCH : ST_MISMATCH;
      res_length            = len_wide[LEN_W-1:0];
      res_rx                = hex_accum;
      res_calc              = crc_at_bang;
      byte_count_next       = '0;
      crc_running_next      = '0;
      crc_at_bang_next      = '0;
      bang_seen_next        = 1'b0;
      chars_after_bang_next = '0;
      hex_accum_next        = '0;
      hex_all_valid_next    = 1'b1;
    end else begin
      byte_count_next  = cnt_inc;
      crc_running_next = crc_new;
      if (it.is_bang) begin
        crc_at_bang_next      = crc_new;
        bang_seen_next        = 1'b1;
        chars_after_bang_next = '0;
        hex_accum_next        = '0;
        hex_all_valid_next    = 1'b1;
      end else if (bang_seen && !chars_after_bang[2]) begin
        hex_accum_next        = {hex_accum[11:0], it.hex_ok ? it.hex_val : 4'h0};
        hex_all_valid_next    = hex_all_valid && it.hex_ok;
        chars_after_bang_next = chars_after_bang + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      crc_running      <= '0;
      crc_at_bang      <= '0;
      bang_seen        <= 1'b0;
      chars_after_bang <= '0;
      hex_accum        <= '0;
      hex_all_valid    <= 1'b1;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        byte_count       <= byte_count_next;
        crc_running      <= crc_running_next;
        crc_at_bang      <= crc_at_bang_next;
        bang_seen        <= bang_seen_next;
        chars_after_bang <= chars_after_bang_next;
        hex_accum        <= hex_accum_next;
        hex_all_valid    <= hex_all_valid_next;
        if (res_fire) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_fire) begin
      status       <= res_status;
      frame_length <= res_length;
      crc_received <= res_rx;
      crc_computed <= res_calc;
    end
  end

`ifndef SYNTH
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (take && res_fire) |=> (byte_count == '0 && !bang_seen))
    else $error("frame state not restarted after result");
  a_overflow_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OVERFLOW) |->
      (frame_length == '0 && crc_received == '0 && crc_computed == '0))
    else $error("overflow result carries payload");
`endif

endmodule

/* hw/rtl/p1_telegram_crc_checker_unit.sv */
// An accepted request is written into the queue; the frame engine takes it
// when the output register is free or being drained and registers its result.
// Throughput: one byte per cycle while the output is not stalled, set by
// the combinational CRC-16 byte update in the frame engine; a stalled output
// holds back at most 2 queued requests before in_ready drops.
// Reset: synchronous rst clears the queue, the frame state and out_valid.
// ----------------------------------------------------------------------------
// p1_telegram_crc_checker_unit: P1 telegram CRC-16/ARC checker
// Counts the bytes of a telegram, keeps a running CRC, snapshots it at the
// last '!' and checks the four hex digits that follow on the newline.
// ----------------------------------------------------------------------------
module p1_telegram_crc_checker_unit #(
  parameter int FRAME_BUFFER_BYTES = ptcc_pkg::FRAME_BUFFER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptcc_pkg::STATUS_W-1:0] status,
  output logic [ptcc_pkg::LEN_W-1:0]    frame_length,
  output logic [ptcc_pkg::CRC_W-1:0]    crc_received,
  output logic [ptcc_pkg::CRC_W-1:0]    crc_computed
);
  import ptcc_pkg::*;

  // Front end -> queue: classified request
  logic       push;
  logic       q_full;
  ptcc_item_t push_item;

  // Queue -> frame engine: head of queue and pop
  ptcc_head_t head;
  logic       pop;

  // Classify each request: flush flag, '!' and newline detect, hex digit.
  // Hold the request off only while the queue is full.
  ptcc_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple input from a stalled output register
  ptcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .head      (head),
    .pop       (pop)
  );

  // Advance the frame state one request per cycle whenever the output
  // register is free or being drained; drop overflowing bytes.
  ptcc_back #(
    .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .frame_length (frame_length),
    .crc_received (crc_received),
    .crc_computed (crc_computed)
  );

endmodule
